### rtl/phase_delay_gate_firing_assert.svh
// Assertion macros for the gate firing RTL.
// No dependencies; included inside the module body before the logic.
`ifndef PHASE_DELAY_GATE_FIRING_ASSERT_SVH
`define PHASE_DELAY_GATE_FIRING_ASSERT_SVH

// same-cycle implication
`define PDG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PDG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pdg_pkg.sv
// Shared constants and types for the phase delay gate firing block.
// No dependencies.
package pdg_pkg;

	localparam int HALF_W          = 16;
	localparam int FRAC_W          = 8;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int DATA_W          = 32;
	localparam int ADDR_W          = 3;
	localparam int DIV_CNT_W       = $clog2(HALF_W + 1);

	localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(8330);
	localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(2);

	// register index = paddr[2]
	localparam logic REG_HALF = 1'b0;
	localparam logic REG_FRAC = 1'b1;

	typedef struct packed {
		logic [HALF_W-1:0] half_period_us;
		logic [FRAC_W-1:0] wave_fraction;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### rtl/pdg_if.sv
// Valid/ready channel interfaces for the tick input and the gate result.
// No dependencies.
interface pdg_tick_if;
	logic valid;
	logic ready;
	logic signal_in;

	modport source (output valid, output signal_in, input ready);
	modport sink (input valid, input signal_in, output ready);
endinterface

interface pdg_gate_if;
	logic valid;
	logic ready;
	logic gate_drive;
	logic firing_pending;

	modport source (output valid, output gate_drive, output firing_pending, input ready);
	modport sink (input valid, input gate_drive, input firing_pending, output ready);
endinterface

### rtl/pdg_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on pdg_pkg.
module pdg_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pdg_pkg::HALF_W-1:0]   dividend,
	input  logic [pdg_pkg::FRAC_W-1:0]   divisor,
	output logic [pdg_pkg::HALF_W-1:0]   quotient,
	output logic [pdg_pkg::FRAC_W-1:0]   remainder,
	output pdg_pkg::div_stat_t           stat
);
	import pdg_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [HALF_W-1:0]    quo_q;
	logic [FRAC_W-1:0]    rem_q;
	logic [FRAC_W-1:0]    dvs_q;

	logic [FRAC_W:0] trial;
	logic [FRAC_W:0] diff;
	logic            ge;

	assign trial = {rem_q, quo_q[HALF_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(HALF_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FRAC_W-1:0] : trial[FRAC_W-1:0];
			quo_q <= {quo_q[HALF_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat      = '{busy: busy_q, done: done_q};

endmodule

### rtl/pdg_cfg.sv
// APB register file: half period and wave fraction.
// Depends on pdg_pkg.
module pdg_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pdg_pkg::ADDR_W-1:0]  paddr,
	input  logic [pdg_pkg::DATA_W-1:0]  pwdata,
	output logic [pdg_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output pdg_pkg::cfg_t               cfg
);
	import pdg_pkg::*;

	logic [HALF_W-1:0] half_q;
	logic [FRAC_W-1:0] frac_q;
	logic              wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
			frac_q <= FRAC_RESET;
		end else if (wr) begin
			unique case (paddr[2])
				REG_HALF: half_q <= pwdata[HALF_W-1:0];
				REG_FRAC: frac_q <= pwdata[FRAC_W-1:0];
				default:  half_q <= half_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HALF: prdata = DATA_W'(half_q);
			REG_FRAC: prdata = DATA_W'(frac_q);
			default:  prdata = '0;
		endcase
	end

	assign cfg = '{half_period_us: half_q, wave_fraction: frac_q};

endmodule

### rtl/phase_delay_gate_firing.sv
// Top level of the phase delay gate firing controller.
// Depends on pdg_pkg, pdg_if, pdg_cfg, pdg_div and the assert macro header.
//
//  channel | dir | fields                         | transfer
//  --------+-----+--------------------------------+------------------------
//  tick    | in  | signal_in                      | tick.valid & tick.ready
//  gate    | out | gate_drive, firing_pending     | gate.valid & gate.ready
//  apb     | in  | half_period_us, wave_fraction  | psel & penable & pwrite
//
// A tick is handled directly, except a rising edge seen outside a running delay:
// that tick goes through accept, 16 steps of the serial divider, and result.
// The serial divider, one quotient bit per cycle, sets the length of that path.
// Reset (arst_n low) clears edge history, countdown, pending and gate level;
// the registers return to 8330 and 2. No clearing pass is needed.
// A new tick is taken while the last result waits, as long as that result
// leaves in the same cycle; a stalled result holds the input off.
module phase_delay_gate_firing #(
	parameter int COUNT_WIDTH = pdg_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pdg_tick_if.sink                    tick,
	pdg_gate_if.source                  gate,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pdg_pkg::ADDR_W-1:0]  paddr,
	input  logic [pdg_pkg::DATA_W-1:0]  pwdata,
	output logic [pdg_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import pdg_pkg::*;

	`include "phase_delay_gate_firing_assert.svh"

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;
	// wait value is 16 bits; widen to the larger of that and the counter
	localparam int WW = (COUNT_WIDTH > HALF_W) ? COUNT_WIDTH : HALF_W;

	cfg_t              cfg;
	div_stat_t         div_stat;
	logic [HALF_W-1:0] div_quo;
	logic [FRAC_W-1:0] div_rem;
	logic [FRAC_W-1:0] frac_eff;

	logic                   state_q;
	logic                   out_valid_q;
	logic                   prev_q;
	logic                   pending_q;
	logic                   gate_q;
	logic [COUNT_WIDTH-1:0] countdown_q;
	logic [HALF_W-1:0]      half_q;

	logic                   accept;
	logic                   rise;
	logic                   fall;
	logic                   div_start;
	logic [COUNT_WIDTH-1:0] cnt_dec;
	logic [HALF_W-1:0]      wait16;
	logic [WW-1:0]          wait_wide;
	logic [COUNT_WIDTH-1:0] wait_sat;

	pdg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// a fraction of zero acts as one: no delay
	assign frac_eff = (cfg.wave_fraction == '0) ? FRAC_W'(1) : cfg.wave_fraction;

	pdg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (cfg.half_period_us),
		.divisor   (frac_eff),
		.quotient  (div_quo),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	// handshake: idle, and the result slot free or draining this cycle
	assign tick.ready = (state_q == ST_IDLE) && (!out_valid_q || gate.ready);
	assign accept     = tick.valid && tick.ready;

	assign rise      = !prev_q && tick.signal_in;
	assign fall      = prev_q && !tick.signal_in;
	assign div_start = accept && !pending_q && rise;
	assign cnt_dec   = countdown_q - 1'b1;

	// floor(h*(N-1)/N) = h - ceil(h/N)
	assign wait16    = half_q - div_quo - HALF_W'(div_rem != '0);
	assign wait_wide = WW'(wait16);
	assign wait_sat  = (wait_wide > WW'({COUNT_WIDTH{1'b1}})) ? {COUNT_WIDTH{1'b1}}
	                                                           : wait_wide[COUNT_WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (div_start) begin
			half_q <= cfg.half_period_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			prev_q      <= 1'b0;
			pending_q   <= 1'b0;
			gate_q      <= 1'b0;
			countdown_q <= '0;
		end else begin
			// result slot
			if ((accept && !div_start) || div_stat.done) begin
				out_valid_q <= 1'b1;
			end else if (gate.ready) begin
				out_valid_q <= 1'b0;
			end

			priority if (div_start) begin
				state_q <= ST_DIV;
				prev_q  <= 1'b1;
			end else if (div_stat.done) begin
				state_q <= ST_IDLE;
				if (wait_sat == '0) begin
					gate_q <= 1'b1;
				end else begin
					countdown_q <= wait_sat;
					pending_q   <= 1'b1;
				end
			end else if (accept && pending_q) begin
				// samples are ignored while the delay runs
				countdown_q <= cnt_dec;
				if (cnt_dec == '0) begin
					gate_q    <= 1'b1;
					pending_q <= 1'b0;
					prev_q    <= 1'b1;
				end
			end else if (accept) begin
				if (fall) begin
					gate_q <= 1'b0;
				end
				prev_q <= tick.signal_in;
			end
		end
	end

	assign gate.valid          = out_valid_q;
	assign gate.gate_drive     = gate_q;
	assign gate.firing_pending = pending_q;

	`PDG_ASSERT_IMP(a_idle_div_quiet, clk, arst_n, state_q == ST_IDLE, !div_stat.busy && !div_stat.done, "divider active while idle")
	`PDG_ASSERT_IMP(a_done_slot_free, clk, arst_n, div_stat.done, !out_valid_q && state_q == ST_DIV, "divider result with busy result slot")
	`PDG_ASSERT_IMP(a_pending_count, clk, arst_n, pending_q, countdown_q != '0, "pending with empty countdown")
	`PDG_ASSERT_NXT(a_start_enters_div, clk, arst_n, div_start, state_q == ST_DIV && div_stat.busy, "start did not launch divider")

endmodule
